[src/tfb_pkg.sv]
// ----------------------------------------------------------------------------
// tfb_pkg: shared types and codes of the task FIFO bank
// Operation and status codes, the stored task word and the result row.
// ----------------------------------------------------------------------------
package tfb_pkg;

	// operation codes
	typedef enum logic [2:0] {
		KIND_ENQ       = 3'd0,
		KIND_DEQ       = 3'd1,
		KIND_PEEK      = 3'd2,
		KIND_PAUSE     = 3'd3,
		KIND_RESUME    = 3'd4,
		KIND_DRAIN     = 3'd5,
		KIND_MOVE_ALL  = 3'd6,
		KIND_MOVE_HALF = 3'd7
	} kind_t;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	// one stored task
	typedef struct packed {
		logic        paused;
		logic [7:0]  type_code;
		logic [7:0]  priority_req;
		logic [7:0]  zone;
		logic [31:0] value_bits;
		logic [15:0] task_id;
	} task_t;

	// one result row
	typedef struct packed {
		logic [1:0] status;
		task_t      tsk;
		logic [4:0] done_count;
		logic [4:0] skip_count;
		logic [4:0] queue_size;
		logic [6:0] total_tasks;
		logic       last;
	} rsp_t;

endpackage

[src/tfb_if.sv]
// ----------------------------------------------------------------------------
// tfb_req_if / tfb_rsp_if: request and result channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tfb_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [1:0]  queue_sel;
	logic [1:0]  other_queue;
	logic [15:0] task_id;
	logic [7:0]  zone;
	logic [31:0] value_bits;
	logic [7:0]  priority_req;
	logic [7:0]  type_code;

	modport source (
		output valid, kind, queue_sel, other_queue, task_id, zone, value_bits,
		       priority_req, type_code,
		input  ready
	);
	modport sink (
		input  valid, kind, queue_sel, other_queue, task_id, zone, value_bits,
		       priority_req, type_code,
		output ready
	);
endinterface

interface tfb_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] out_task_id;
	logic [7:0]  out_zone;
	logic [31:0] out_value_bits;
	logic [7:0]  out_priority;
	logic [7:0]  out_type_code;
	logic        out_paused;
	logic [4:0]  done_count;
	logic [4:0]  skip_count;
	logic [4:0]  queue_size;
	logic [6:0]  total_tasks;
	logic        last;

	modport source (
		output valid, status, out_task_id, out_zone, out_value_bits, out_priority,
		       out_type_code, out_paused, done_count, skip_count, queue_size,
		       total_tasks, last,
		input  ready
	);
	modport sink (
		input  valid, status, out_task_id, out_zone, out_value_bits, out_priority,
		       out_type_code, out_paused, done_count, skip_count, queue_size,
		       total_tasks, last,
		output ready
	);
endinterface

[src/tfb_outreg.sv]
// ----------------------------------------------------------------------------
// tfb_outreg: result output register
// Holds one result item until the sink takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module tfb_outreg import tfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rsp_t      row,
	output logic      can_push,
	tfb_rsp_if.source rsp
);

	logic valid_q;
	rsp_t row_q;

	// accept a new row when empty or when the held one leaves now
	assign can_push = !valid_q || rsp.ready;

	// track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_push) begin
			valid_q <= push;
		end
	end

	// load payload
	always_ff @(posedge clk) begin
		if (push && can_push) begin
			row_q <= row;
		end
	end

	assign rsp.valid          = valid_q;
	assign rsp.status         = row_q.status;
	assign rsp.out_task_id    = row_q.tsk.task_id;
	assign rsp.out_zone       = row_q.tsk.zone;
	assign rsp.out_value_bits = row_q.tsk.value_bits;
	assign rsp.out_priority   = row_q.tsk.priority_req;
	assign rsp.out_type_code  = row_q.tsk.type_code;
	assign rsp.out_paused     = row_q.tsk.paused;
	assign rsp.done_count     = row_q.done_count;
	assign rsp.skip_count     = row_q.skip_count;
	assign rsp.queue_size     = row_q.queue_size;
	assign rsp.total_tasks    = row_q.total_tasks;
	assign rsp.last           = row_q.last;

endmodule

[src/task_fifo_bank_with_pause.sv]
// Sequence: enqueue, empty and full answers go from the start state straight to the
// final state; dequeue and peek read the head entry once; pause/resume read and test
// one entry per read/process step until a match or the end; moves take one task per
// step; drain walks the queue twice (a counting pass and a compaction pass). One item
// at a time: the next is accepted in the idle state after the last row loads, and a
// stalled output holds the block. Reset: all queues empty, head pointers zero; task memory is not cleared.
// ----------------------------------------------------------------------------
// task_fifo_bank_with_pause: bank of bounded task FIFOs with pause
// Circular queues in one task memory with enqueue, dequeue, peek, pause,
// resume, drain and move operations.
// ----------------------------------------------------------------------------
module task_fifo_bank_with_pause import tfb_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int NUM_QUEUES = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	tfb_req_if.sink   req,
	tfb_rsp_if.source rsp
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int MD = NUM_QUEUES * DEPTH;
	localparam int AW = $clog2(MD);
	localparam int TW = $clog2(MD + 1);
	localparam logic [AW-1:0] QSTRIDE = AW'(DEPTH);
	localparam logic [CW-1:0] FULLCNT = CW'(DEPTH);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_START = 5'b00010,
		S_RD    = 5'b00100,
		S_PROC  = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	// wrap a head-plus-offset sum into the ring
	function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s);
		logic [SW-1:0] t;
		t = s;
		if (t >= SW'(DEPTH)) begin
			t = t - SW'(DEPTH);
		end
		return PW'(t);
	endfunction

	// memory address of the entry at an offset from a queue head
	function automatic logic [AW-1:0] slot(input logic [QW-1:0] qi,
		input logic [PW-1:0] h, input logic [CW-1:0] off);
		return AW'(qi) * QSTRIDE + AW'(wrap(SW'(h) + SW'(off)));
	endfunction

	// fold a queue number into the bank
	function automatic logic [QW-1:0] qmod(input logic [1:0] v);
		logic [3:0] t;
		t = {2'b00, v};
		if (t >= 4'(NUM_QUEUES)) begin
			t = t - 4'(NUM_QUEUES);
		end
		return QW'(t);
	endfunction

	state_t         state_q;
	kind_t          kind_q;
	logic [QW-1:0]  qs_q, qd_q;
	task_t          tin_q, tsk_q, rd_q, mem_wd;
	logic [CW-1:0]  idx_q, cq_q, kept_q, kw_q, done_q, want_q;
	logic           pass2_q, tshow_q;
	logic [1:0]     st_q;
	logic [AW-1:0]  ra_q, rd_addr, mem_wa;
	logic [PW-1:0]  head_q [NUM_QUEUES];
	logic [CW-1:0]  cnt_q  [NUM_QUEUES];
	logic [TW-1:0]  total_q;
	task_t          mem [MD];

	logic [CW-1:0]  cur_cnt, dst_cnt, rd_off;
	logic [PW-1:0]  cur_head, dst_head;
	logic           go_rd, mem_we, match, can_push, push;
	rsp_t           row;

	assign req.ready = (state_q == S_IDLE);

	assign cur_cnt  = cnt_q[qs_q];
	assign dst_cnt  = cnt_q[qd_q];
	assign cur_head = head_q[qs_q];
	assign dst_head = head_q[qd_q];
	assign match    = (rd_q.task_id == tin_q.task_id);

	// read offset: walking operations index, the rest take the head
	always_comb begin
		unique case (kind_q)
			KIND_PAUSE, KIND_RESUME, KIND_DRAIN: rd_off = idx_q;
			default:                             rd_off = '0;
		endcase
	end
	assign rd_addr = slot(qs_q, cur_head, rd_off);

	// decide whether another entry is read
	always_comb begin
		unique case (kind_q)
			KIND_PAUSE, KIND_RESUME, KIND_DRAIN: go_rd = (idx_q != cq_q);
			KIND_MOVE_ALL:  go_rd = (cur_cnt != '0) && (dst_cnt != FULLCNT);
			KIND_MOVE_HALF: go_rd = (done_q != want_q) &&
			                        ((qs_q == qd_q) || (dst_cnt != FULLCNT));
			default:        go_rd = 1'b1;
		endcase
	end

	// memory write select
	always_comb begin
		mem_we = 1'b0;
		mem_wa = rd_addr;
		mem_wd = rd_q;
		if (state_q == S_START) begin
			mem_we = (kind_q == KIND_ENQ) && (cur_cnt != FULLCNT);
			mem_wa = slot(qs_q, cur_head, cur_cnt);
			mem_wd = tin_q;
		end else if (state_q == S_PROC) begin
			unique case (kind_q)
				KIND_PAUSE, KIND_RESUME: begin
					mem_we        = match;
					mem_wa        = ra_q;
					mem_wd.paused = (kind_q == KIND_PAUSE);
				end
				KIND_DRAIN: begin
					mem_we = pass2_q && rd_q.paused;
					mem_wa = slot(qs_q, cur_head, kw_q);
				end
				KIND_MOVE_ALL: begin
					mem_we = 1'b1;
					mem_wa = AW'(qd_q) * QSTRIDE
					       + AW'(wrap(SW'(dst_head) + SW'(DEPTH - 1)));
				end
				KIND_MOVE_HALF: begin
					mem_we = 1'b1;
					mem_wa = slot(qd_q, dst_head, dst_cnt);
				end
				default: mem_we = 1'b0;
			endcase
		end
	end

	// task memory: one access per cycle, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == S_RD && go_rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	// build result rows: drain rows in the walk, all others at the end
	always_comb begin
		row             = '0;
		row.queue_size  = 5'(cur_cnt);
		row.total_tasks = 7'(total_q);
		push            = 1'b0;
		if (state_q == S_FIN) begin
			push           = 1'b1;
			row.status     = st_q;
			row.tsk        = tshow_q ? tsk_q : '0;
			row.done_count = 5'(done_q);
			row.skip_count = 5'(kept_q);
			row.last       = 1'b1;
		end else if (state_q == S_PROC && kind_q == KIND_DRAIN && pass2_q
		             && !rd_q.paused) begin
			push       = 1'b1;
			row.status = ST_OK;
			row.tsk    = rd_q;
		end
	end

	tfb_outreg u_outreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.row      (row),
		.can_push (can_push),
		.rsp      (rsp)
	);

	// hold per-item payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			kind_q <= kind_t'(req.kind);
			qs_q   <= qmod(req.queue_sel);
			qd_q   <= qmod(req.other_queue);
			tin_q  <= '{paused: 1'b0, type_code: req.type_code,
			           priority_req: req.priority_req, zone: req.zone,
			           value_bits: req.value_bits, task_id: req.task_id};
		end
		if (state_q == S_RD && go_rd) begin
			ra_q <= rd_addr;
		end
	end

	// sequencer and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			idx_q   <= '0;
			cq_q    <= '0;
			kept_q  <= '0;
			kw_q    <= '0;
			done_q  <= '0;
			want_q  <= '0;
			pass2_q <= 1'b0;
			tshow_q <= 1'b0;
			st_q    <= ST_OK;
			tsk_q   <= '0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						idx_q   <= '0;
						kept_q  <= '0;
						kw_q    <= '0;
						done_q  <= '0;
						pass2_q <= 1'b0;
						tshow_q <= 1'b0;
						st_q    <= ST_OK;
						state_q <= S_START;
					end
				end
				S_START: begin
					cq_q   <= cur_cnt;
					want_q <= cur_cnt >> 1;
					priority if (kind_q != KIND_ENQ && cur_cnt == '0) begin
						st_q    <= ST_EMPTY;
						state_q <= S_FIN;
					end else if (kind_q == KIND_ENQ) begin
						if (cur_cnt == FULLCNT) begin
							st_q <= ST_FULL;
						end else begin
							cnt_q[qs_q] <= cur_cnt + 1'b1;
							total_q     <= total_q + 1'b1;
							tsk_q       <= tin_q;
							tshow_q     <= 1'b1;
						end
						state_q <= S_FIN;
					end else if (kind_q == KIND_MOVE_ALL && qs_q == qd_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (go_rd) begin
						state_q <= S_PROC;
					end else begin
						unique case (kind_q)
							KIND_PAUSE, KIND_RESUME: begin
								st_q    <= ST_NOT_FOUND;
								state_q <= S_FIN;
							end
							KIND_DRAIN: begin
								if (!pass2_q) begin
									// settle sizes, then compact
									cnt_q[qs_q] <= kept_q;
									total_q     <= total_q - TW'(cq_q - kept_q);
									pass2_q     <= 1'b1;
									idx_q       <= '0;
								end else begin
									state_q <= S_FIN;
								end
							end
							KIND_MOVE_ALL: begin
								if (cur_cnt != '0) begin
									st_q <= ST_FULL;
								end
								state_q <= S_FIN;
							end
							KIND_MOVE_HALF: begin
								if (done_q != want_q) begin
									st_q <= ST_FULL;
								end
								state_q <= S_FIN;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_PROC: begin
					unique case (kind_q)
						KIND_DEQ: begin
							tsk_q        <= rd_q;
							tshow_q      <= 1'b1;
							head_q[qs_q] <= wrap(SW'(cur_head) + SW'(1));
							cnt_q[qs_q]  <= cur_cnt - 1'b1;
							total_q      <= total_q - 1'b1;
							state_q      <= S_FIN;
						end
						KIND_PEEK: begin
							tsk_q   <= rd_q;
							tshow_q <= 1'b1;
							state_q <= S_FIN;
						end
						KIND_PAUSE, KIND_RESUME: begin
							if (match) begin
								tsk_q   <= mem_wd;
								tshow_q <= 1'b1;
								state_q <= S_FIN;
							end else begin
								idx_q   <= idx_q + 1'b1;
								state_q <= S_RD;
							end
						end
						KIND_DRAIN: begin
							if (!pass2_q) begin
								kept_q  <= kept_q + CW'(rd_q.paused);
								idx_q   <= idx_q + 1'b1;
								state_q <= S_RD;
							end else if (rd_q.paused) begin
								kw_q    <= kw_q + 1'b1;
								idx_q   <= idx_q + 1'b1;
								state_q <= S_RD;
							end else if (can_push) begin
								done_q  <= done_q + 1'b1;
								idx_q   <= idx_q + 1'b1;
								state_q <= S_RD;
							end
						end
						KIND_MOVE_ALL: begin
							head_q[qs_q] <= wrap(SW'(cur_head) + SW'(1));
							cnt_q[qs_q]  <= cur_cnt - 1'b1;
							head_q[qd_q] <= wrap(SW'(dst_head) + SW'(DEPTH - 1));
							cnt_q[qd_q]  <= dst_cnt + 1'b1;
							done_q       <= done_q + 1'b1;
							state_q      <= S_RD;
						end
						KIND_MOVE_HALF: begin
							head_q[qs_q] <= wrap(SW'(cur_head) + SW'(1));
							if (qs_q != qd_q) begin
								cnt_q[qs_q] <= cur_cnt - 1'b1;
								cnt_q[qd_q] <= dst_cnt + 1'b1;
							end
							done_q  <= done_q + 1'b1;
							state_q <= S_RD;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_FIN: begin
					if (can_push) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the task FIFO bank
// Feeds directed then random operations with bursty input and a stalling
// output, predicts every result row and checks each row in order.
// ----------------------------------------------------------------------------
module tb_top import tfb_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH  = 16;
	localparam int NQ     = 4;
	localparam int LIMIT  = 400000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  queue_sel;
		logic [1:0]  other_queue;
		logic [15:0] task_id;
		logic [7:0]  zone;
		logic [31:0] value_bits;
		logic [7:0]  priority_req;
		logic [7:0]  type_code;
	} op_t;

	// Bank predictor and pending result rows
	class bank_scoreboard;
		task_t    slot_q[NQ][$];
		rsp_t     pending[$];
		int       errors;
		int       rows_seen;

		function rsp_t blank(logic [1:0] st);
			rsp_t r;
			r = '0;
			r.status = st;
			return r;
		endfunction

		function void note_op(op_t op);
			rsp_t   rows[$];
			rsp_t   r;
			task_t  t;
			task_t  kept[$];
			int     q, d, moved, done, idx, total, want;
			logic [1:0] st;
			q = op.queue_sel % NQ;
			d = op.other_queue % NQ;
			if (op.kind != KIND_ENQ && slot_q[q].size() == 0) begin
				rows.push_back(blank(ST_EMPTY));
			end else begin
				case (kind_t'(op.kind))
					KIND_ENQ: begin
						if (slot_q[q].size() >= DEPTH) begin
							rows.push_back(blank(ST_FULL));
						end else begin
							t = '{1'b0, op.type_code, op.priority_req, op.zone,
								op.value_bits, op.task_id};
							slot_q[q].push_back(t);
							r = blank(ST_OK);
							r.tsk = t;
							rows.push_back(r);
						end
					end
					KIND_DEQ, KIND_PEEK: begin
						r = blank(ST_OK);
						r.tsk = (op.kind == KIND_DEQ) ? slot_q[q].pop_front() : slot_q[q][0];
						rows.push_back(r);
					end
					KIND_PAUSE, KIND_RESUME: begin
						idx = -1;
						for (int i = 0; i < slot_q[q].size(); i++)
							if (idx < 0 && slot_q[q][i].task_id == op.task_id) idx = i;
						if (idx < 0) begin
							rows.push_back(blank(ST_NOT_FOUND));
						end else begin
							slot_q[q][idx].paused = (op.kind == KIND_PAUSE);
							r = blank(ST_OK);
							r.tsk = slot_q[q][idx];
							rows.push_back(r);
						end
					end
					KIND_DRAIN: begin
						// emit unpaused tasks, keep paused ones in order
						done = 0;
						kept = {};
						for (int i = 0; i < slot_q[q].size(); i++) begin
							if (slot_q[q][i].paused) begin
								kept.push_back(slot_q[q][i]);
							end else begin
								r = blank(ST_OK);
								r.tsk = slot_q[q][i];
								rows.push_back(r);
								done++;
							end
						end
						slot_q[q] = kept;
						r = blank(ST_OK);
						r.done_count = 5'(done);
						r.skip_count = 5'(kept.size());
						rows.push_back(r);
					end
					KIND_MOVE_ALL: begin
						moved = 0;
						st = ST_OK;
						if (q != d) begin
							while (slot_q[q].size() > 0) begin
								if (slot_q[d].size() >= DEPTH) begin
									st = ST_FULL;
									break;
								end
								slot_q[d].push_front(slot_q[q].pop_front());
								moved++;
							end
						end
						r = blank(st);
						r.done_count = 5'(moved);
						rows.push_back(r);
					end
					default: begin
						want = slot_q[q].size() / 2;
						moved = 0;
						st = ST_OK;
						while (moved < want) begin
							if (q != d && slot_q[d].size() >= DEPTH) begin
								st = ST_FULL;
								break;
							end
							slot_q[d].push_back(slot_q[q].pop_front());
							moved++;
						end
						r = blank(st);
						r.done_count = 5'(moved);
						rows.push_back(r);
					end
				endcase
			end
			total = 0;
			for (int i = 0; i < NQ; i++) total += slot_q[i].size();
			foreach (rows[k]) begin
				rows[k].queue_size  = 5'(slot_q[q].size());
				rows[k].total_tasks = 7'(total);
				rows[k].last        = (k == rows.size() - 1);
				pending.push_back(rows[k]);
			end
		endfunction

		function void check_row(rsp_t got);
			rsp_t want;
			rows_seen++;
			if (pending.size() == 0) begin
				$error("result row with nothing expected");
				errors++;
				return;
			end
			want = pending.pop_front();
			cmp("status", 32'(want.status), 32'(got.status));
			cmp("out_task_id", 32'(want.tsk.task_id), 32'(got.tsk.task_id));
			cmp("out_zone", 32'(want.tsk.zone), 32'(got.tsk.zone));
			cmp("out_value_bits", want.tsk.value_bits, got.tsk.value_bits);
			cmp("out_priority", 32'(want.tsk.priority_req), 32'(got.tsk.priority_req));
			cmp("out_type_code", 32'(want.tsk.type_code), 32'(got.tsk.type_code));
			cmp("out_paused", 32'(want.tsk.paused), 32'(got.tsk.paused));
			cmp("done_count", 32'(want.done_count), 32'(got.done_count));
			cmp("skip_count", 32'(want.skip_count), 32'(got.skip_count));
			cmp("queue_size", 32'(want.queue_size), 32'(got.queue_size));
			cmp("total_tasks", 32'(want.total_tasks), 32'(got.total_tasks));
			cmp("last", 32'(want.last), 32'(got.last));
		endfunction

		function void cmp(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$error("%s: expected %0h, got %0h", name, e, a);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	bit   hold_off;
	bit   stim_done;
	int   ops_sent;
	bank_scoreboard sb;

	tfb_req_if req ();
	tfb_rsp_if rsp ();

	task_fifo_bank_with_pause #(.DEPTH(DEPTH), .NUM_QUEUES(NQ)) dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Check result rows at the rising edge
	always @(posedge clk) begin
		rsp_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.status      = rsp.status;
			got.tsk         = '{rsp.out_paused, rsp.out_type_code, rsp.out_priority,
				rsp.out_zone, rsp.out_value_bits, rsp.out_task_id};
			got.done_count  = rsp.done_count;
			got.skip_count  = rsp.skip_count;
			got.queue_size  = rsp.queue_size;
			got.total_tasks = rsp.total_tasks;
			got.last        = rsp.last;
			sb.check_row(got);
		end
	end

	// Receiver stall pattern, with one long hold-off
	always @(negedge clk) begin
		if (!arst_n || hold_off) begin
			rsp.ready <= 1'b0;
		end else if ((cycles / 200) % 3 == 0) begin
			rsp.ready <= 1'b1;
		end else begin
			rsp.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		hold_off = 1'b0;
		wait (ops_sent >= 120);
		hold_off = 1'b1;
		repeat (600) @(posedge clk);
		hold_off = 1'b0;
	end

	// Send one item; hold valid until accepted
	task automatic send_op(op_t op);
		req.valid        <= 1'b1;
		req.kind         <= op.kind;
		req.queue_sel    <= op.queue_sel;
		req.other_queue  <= op.other_queue;
		req.task_id      <= op.task_id;
		req.zone         <= op.zone;
		req.value_bits   <= op.value_bits;
		req.priority_req <= op.priority_req;
		req.type_code    <= op.type_code;
		do @(posedge clk); while (!req.ready);
		sb.note_op(op);
		ops_sent++;
		@(negedge clk);
	endtask

	// Insert a random gap after a burst
	task automatic pace(inout int burst);
		if (burst > 0) begin
			burst--;
			return;
		end
		req.valid <= 1'b0;
		repeat ($urandom_range(1, 12)) @(negedge clk);
		burst = $urandom_range(0, 20);
	endtask

	function automatic op_t make_op(kind_t k, int q, int d, logic [15:0] id);
		op_t op;
		op.kind         = k;
		op.queue_sel    = 2'(q);
		op.other_queue  = 2'(d);
		op.task_id      = id;
		op.zone         = 8'($urandom);
		op.value_bits   = $urandom;
		op.priority_req = 8'($urandom);
		op.type_code    = 8'($urandom);
		return op;
	endfunction

	// Random op biased toward a small id pool so searches hit
	function automatic op_t rand_op();
		int    r;
		kind_t k;
		r = $urandom_range(0, 99);
		if (r < 40)      k = KIND_ENQ;
		else if (r < 52) k = KIND_DEQ;
		else if (r < 58) k = KIND_PEEK;
		else if (r < 70) k = KIND_PAUSE;
		else if (r < 76) k = KIND_RESUME;
		else if (r < 84) k = KIND_DRAIN;
		else if (r < 92) k = KIND_MOVE_ALL;
		else             k = KIND_MOVE_HALF;
		return make_op(k, $urandom_range(0, 3), $urandom_range(0, 3),
			($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15)));
	endfunction

	initial begin
		op_t op;
		int  burst;
		int  wait_cnt;
		sb = new();
		cycles = 0;
		ops_sent = 0;
		stim_done = 0;
		req.valid = 1'b0;
		req.kind = '0; req.queue_sel = '0; req.other_queue = '0; req.task_id = '0;
		req.zone = '0; req.value_bits = '0; req.priority_req = '0; req.type_code = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty queue answers, extremes, fill, full, pause, drain, moves
		for (int k = 1; k < 8; k++) send_op(make_op(kind_t'(k), 3, 0, 16'h0));
		op = make_op(KIND_ENQ, 0, 0, 16'hFFFF);
		op.zone = 8'hFF; op.value_bits = '1; op.priority_req = 8'hFF; op.type_code = 8'hFF;
		send_op(op);
		op = make_op(KIND_ENQ, 0, 0, 16'h0);
		op.zone = 0; op.value_bits = 0; op.priority_req = 0; op.type_code = 0;
		send_op(op);
		for (int i = 0; i < 15; i++) send_op(make_op(KIND_ENQ, 1, 0, 16'(i)));
		send_op(make_op(KIND_PAUSE, 1, 0, 16'd3));
		send_op(make_op(KIND_PAUSE, 1, 0, 16'd77));
		send_op(make_op(KIND_ENQ, 0, 0, 16'd5));
		send_op(make_op(KIND_MOVE_ALL, 1, 0, 16'd0));
		send_op(make_op(KIND_MOVE_HALF, 0, 0, 16'd0));
		send_op(make_op(KIND_MOVE_ALL, 0, 0, 16'd0));
		send_op(make_op(KIND_PEEK, 0, 0, 16'd0));
		send_op(make_op(KIND_DEQ, 0, 0, 16'd0));
		send_op(make_op(KIND_RESUME, 0, 0, 16'd3));
		send_op(make_op(KIND_DRAIN, 0, 0, 16'd0));
		send_op(make_op(KIND_DRAIN, 1, 0, 16'd0));

		// Random phase
		burst = 0;
		for (int n = 0; n < 400; n++) begin
			send_op(rand_op());
			pace(burst);
		end
		req.valid <= 1'b0;
		stim_done = 1;

		// Drain outstanding rows, then let the block settle
		wait_cnt = 0;
		while (sb.pending.size() != 0 && wait_cnt < 50000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (200) @(posedge clk);
		$display("Sent %0d operations over all eight kinds, checked %0d result rows.",
			ops_sent, sb.rows_seen);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			if (sb.pending.size() != 0)
				$error("%0d expected rows never arrived", sb.pending.size());
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

[filelist.f]
src/tfb_pkg.sv
src/tfb_if.sv
src/tfb_outreg.sv
src/task_fifo_bank_with_pause.sv
bench/tb_top.sv
